@@ src/pdl_pkg.sv @@
// ----------------------------------------------------------------------------
// pdl_pkg
// Types, codes and sizes shared by the draw list front end, the command
// queue, the list engine and the top level.
// ----------------------------------------------------------------------------
package pdl_pkg;

	localparam int NumEntries = 32;   // usable entry indices, 0..31
	localparam int NumIds     = 32;   // entry index space and list slots
	localparam int EntryW     = 5;
	localparam int PrioW      = 8;
	localparam int IdxW       = $clog2(NumIds);
	localparam int LenW       = $clog2(NumIds + 1);
	localparam int QueueDepth = 2;
	localparam int QPtrW      = $clog2(QueueDepth);
	localparam int QCntW      = $clog2(QueueDepth + 1);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_CHANGE = 2'd2,
		OP_WALK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_DISABLED = 2'd2,
		ST_MISUSE   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CMD_REPLY,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_CHANGE,
		CMD_WALK
	} cmd_kind_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_WALK,
		BK_RELINK
	} bk_state_t;

	typedef struct packed {
		op_t                op;
		logic [EntryW-1:0]  entry;
		logic [PrioW-1:0]   priority_req;
	} req_t;

	typedef struct packed {
		logic [EntryW-1:0]  entry_out;
		logic [PrioW-1:0]   priority_out;
		logic               last;
		status_t            status;
	} rsp_t;

	// Classified request as handed from the front end to the list engine.
	typedef struct packed {
		cmd_kind_t          kind;
		logic [EntryW-1:0]  entry;
		logic [PrioW-1:0]   prio;
		status_t            status;
	} cmd_t;

	// Handshake between a queue and its reader.
	typedef struct packed {
		logic valid;
		cmd_t cmd;
	} q_head_t;

endpackage

@@ src/pdl_front.sv @@
// ----------------------------------------------------------------------------
// pdl_front
// Accepts requests, checks them against the entry table and turns each into
// a list command or a direct reply. Owns presence, per-entry priority, the
// entry count and the draw enable register.
// ----------------------------------------------------------------------------
module pdl_front import pdl_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	input  req_t  req,
	output logic  req_stall,
	input  logic  cfg_valid,
	input  logic  cfg_data,
	input  logic  q_full,
	output logic  q_push,
	output cmd_t  q_cmd
);

	logic [NumIds-1:0] present_q;
	logic [PrioW-1:0]  prio_q [NumIds];
	logic [LenW-1:0]   count_q;
	logic              enable_q;

	logic accept;
	logic ent_ok;
	logic is_present;
	logic set_present;
	logic clr_present;
	logic set_prio;

	assign req_stall  = q_full;
	assign accept     = req_valid && !q_full;
	assign ent_ok     = 32'(req.entry) < 32'(NumEntries);
	assign is_present = ent_ok && present_q[req.entry];
	assign q_push     = accept;

	always_comb begin
		q_cmd       = '{kind: CMD_REPLY, entry: req.entry, prio: '0, status: ST_MISUSE};
		set_present = 1'b0;
		clr_present = 1'b0;
		set_prio    = 1'b0;
		case (req.op)
			OP_INSERT: begin
				if (ent_ok && !is_present) begin
					q_cmd.kind   = CMD_INSERT;
					q_cmd.prio   = req.priority_req;
					q_cmd.status = ST_OK;
					set_present  = 1'b1;
					set_prio     = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (is_present) begin
					q_cmd.kind   = CMD_REMOVE;
					q_cmd.prio   = prio_q[req.entry];
					q_cmd.status = ST_OK;
					clr_present  = 1'b1;
				end
			end
			OP_CHANGE: begin
				if (is_present) begin
					q_cmd.kind   = CMD_CHANGE;
					q_cmd.prio   = req.priority_req;
					q_cmd.status = ST_OK;
					set_prio     = 1'b1;
				end
			end
			OP_WALK: begin
				q_cmd.entry = '0;
				if (!enable_q) begin
					q_cmd.status = ST_DISABLED;
				end else if (count_q == '0) begin
					q_cmd.status = ST_EMPTY;
				end else begin
					q_cmd.kind   = CMD_WALK;
					q_cmd.status = ST_OK;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			count_q   <= '0;
			enable_q  <= 1'b1;
			for (int i = 0; i < NumIds; i++) prio_q[i] <= '0;
		end else begin
			if (cfg_valid) enable_q <= cfg_data;
			if (accept) begin
				if (set_present) begin
					present_q[req.entry] <= 1'b1;
					count_q              <= count_q + LenW'(1);
				end
				if (clr_present) begin
					present_q[req.entry] <= 1'b0;
					count_q              <= count_q - LenW'(1);
				end
				if (set_prio) prio_q[req.entry] <= req.priority_req;
			end
		end
	end

endmodule

@@ src/pdl_queue.sv @@
// ----------------------------------------------------------------------------
// pdl_queue
// Short command FIFO between the front end and the list engine.
// ----------------------------------------------------------------------------
module pdl_queue import pdl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  cmd_t    push_cmd,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	cmd_t             mem_q [QueueDepth];
	logic [QPtrW-1:0] wr_q;
	logic [QPtrW-1:0] rd_q;
	logic [QCntW-1:0] cnt_q;

	logic do_push;
	logic do_pop;

	assign full       = cnt_q == QCntW'(QueueDepth);
	assign head.valid = cnt_q != '0;
	assign head.cmd   = mem_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (32'(wr_q) == QueueDepth - 1) ? '0 : wr_q + QPtrW'(1);
			end
			if (do_pop) begin
				rd_q <= (32'(rd_q) == QueueDepth - 1) ? '0 : rd_q + QPtrW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + QCntW'(1);
				2'b01:   cnt_q <= cnt_q - QCntW'(1);
				default: ;
			endcase
		end
	end

endmodule

@@ src/pdl_back.sv @@
// ----------------------------------------------------------------------------
// pdl_back
// List engine: a chain of slot cells kept in priority order. Insert and
// remove shift the chain; a walk steps through the slots and feeds the
// response register one entry per cycle while the response is not stalled.
// ----------------------------------------------------------------------------
module pdl_back import pdl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  q_head_t head,
	output logic    pop,
	output logic    rsp_valid,
	output rsp_t    rsp,
	input  logic    rsp_stall
);

	logic [EntryW-1:0] slot_ent_q  [NumIds];
	logic [PrioW-1:0]  slot_prio_q [NumIds];
	logic [LenW-1:0]   len_q;
	logic [IdxW-1:0]   idx_q;
	cmd_t              hold_q;
	bk_state_t         state_q;
	rsp_t              out_q;
	logic              out_valid_q;

	bk_state_t         state_d;
	logic [LenW-1:0]   len_d;
	logic [IdxW-1:0]   idx_d;
	cmd_t              hold_d;
	logic              can_emit;
	logic              emit;
	rsp_t              emit_data;
	logic              do_ins;
	logic              do_rem;
	cmd_t              ins_cmd;
	logic              walk_last;

	logic [NumIds-1:0] le;
	logic [NumIds-1:0] gone;
	logic [EntryW-1:0] ins_ent  [NumIds];
	logic [PrioW-1:0]  ins_prio [NumIds];
	logic [EntryW-1:0] rem_ent  [NumIds];
	logic [PrioW-1:0]  rem_prio [NumIds];

	assign can_emit  = !out_valid_q || !rsp_stall;
	assign ins_cmd   = (state_q == BK_RELINK) ? hold_q : head.cmd;
	assign walk_last = (LenW'(idx_q) + LenW'(1)) == len_q;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	// Insert: cells at or below the new priority hold, the first cell past
	// them takes the new entry, the rest move up by one.
	always_comb begin
		for (int i = 0; i < NumIds; i++) begin
			le[i] = (LenW'(i) < len_q) && (slot_prio_q[i] <= ins_cmd.prio);
		end
		for (int i = 0; i < NumIds; i++) begin
			if (le[i]) begin
				ins_ent[i]  = slot_ent_q[i];
				ins_prio[i] = slot_prio_q[i];
			end else if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
				ins_ent[i]  = ins_cmd.entry;
				ins_prio[i] = ins_cmd.prio;
			end else begin
				ins_ent[i]  = slot_ent_q[(i == 0) ? 0 : i - 1];
				ins_prio[i] = slot_prio_q[(i == 0) ? 0 : i - 1];
			end
		end
	end

	// Remove: every cell from the match onward takes its upper neighbor.
	always_comb begin
		for (int i = 0; i < NumIds; i++) begin
			gone[i] = (LenW'(i) < len_q) && (slot_ent_q[i] == head.cmd.entry);
			if (i > 0) gone[i] = gone[i] | gone[(i == 0) ? 0 : i - 1];
		end
		for (int i = 0; i < NumIds; i++) begin
			if (gone[i] && i + 1 < NumIds) begin
				rem_ent[i]  = slot_ent_q[(i + 1 < NumIds) ? i + 1 : i];
				rem_prio[i] = slot_prio_q[(i + 1 < NumIds) ? i + 1 : i];
			end else begin
				rem_ent[i]  = slot_ent_q[i];
				rem_prio[i] = slot_prio_q[i];
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		len_d     = len_q;
		idx_d     = idx_q;
		hold_d    = hold_q;
		pop       = 1'b0;
		do_ins    = 1'b0;
		do_rem    = 1'b0;
		emit      = 1'b0;
		emit_data = '{entry_out: head.cmd.entry, priority_out: head.cmd.prio,
			last: 1'b1, status: head.cmd.status};
		case (state_q)
			BK_IDLE: begin
				if (head.valid && can_emit) begin
					pop = 1'b1;
					case (head.cmd.kind)
						CMD_REPLY: begin
							emit = 1'b1;
						end
						CMD_INSERT: begin
							do_ins = 1'b1;
							len_d  = len_q + LenW'(1);
							emit   = 1'b1;
						end
						CMD_REMOVE: begin
							do_rem = 1'b1;
							len_d  = len_q - LenW'(1);
							emit   = 1'b1;
						end
						CMD_CHANGE: begin
							do_rem  = 1'b1;
							len_d   = len_q - LenW'(1);
							hold_d  = head.cmd;
							state_d = BK_RELINK;
						end
						CMD_WALK: begin
							idx_d   = '0;
							state_d = BK_WALK;
						end
						default: ;
					endcase
				end
			end
			BK_RELINK: begin
				if (can_emit) begin
					do_ins    = 1'b1;
					len_d     = len_q + LenW'(1);
					emit      = 1'b1;
					emit_data = '{entry_out: hold_q.entry, priority_out: hold_q.prio,
						last: 1'b1, status: ST_OK};
					state_d   = BK_IDLE;
				end
			end
			BK_WALK: begin
				if (can_emit) begin
					emit      = 1'b1;
					emit_data = '{entry_out: slot_ent_q[idx_q], priority_out: slot_prio_q[idx_q],
						last: walk_last, status: ST_OK};
					if (walk_last) begin
						state_d = BK_IDLE;
					end else begin
						idx_d = idx_q + IdxW'(1);
					end
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) out_q <= emit_data;
		hold_q <= hold_d;
		for (int i = 0; i < NumIds; i++) begin
			if (do_ins) begin
				slot_ent_q[i]  <= ins_ent[i];
				slot_prio_q[i] <= ins_prio[i];
			end else if (do_rem) begin
				slot_ent_q[i]  <= rem_ent[i];
				slot_prio_q[i] <= rem_prio[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			len_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q   <= len_d;
			idx_q   <= idx_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ src/priority_ordered_draw_list.sv @@
// Path: an accepted request passes through the command queue, and its result is
//   registered in the response register before it is shown on the response port.
// Engine work: a priority change is an unlink, then a relink; a walk gives
//   one result per listed entry. The engine has a single slot chain and
//   works on one command at a time.
// Reset (arst_n low): list and queue empty, draw enable set, no response.
// ----------------------------------------------------------------------------
// priority_ordered_draw_list
// Draw list kept sorted by 8-bit priority, lowest first, stable among equal
// priorities. Front end classifies requests, a short queue decouples it from
// the list engine, which shifts the slot chain and streams walk results.
// ----------------------------------------------------------------------------
module priority_ordered_draw_list import pdl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	// request channel
	input  logic req_valid,
	input  req_t req,
	output logic req_stall,
	// response channel
	output logic rsp_valid,
	output rsp_t rsp,
	input  logic rsp_stall,
	// draw enable register write
	input  logic cfg_valid,
	input  logic cfg_data,
	output logic cfg_ready
);

	logic    q_full;
	logic    q_push;
	cmd_t    q_cmd;
	logic    q_pop;
	q_head_t q_head;

	// The register is a plain flop in the front end: always take the write.
	assign cfg_ready = 1'b1;

	// Front end: check presence, decide the reply or list command, and
	// advance the entry table at once so later requests see the new state.
	pdl_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_cmd     (q_cmd)
	);

	// Hold classified commands while the engine is busy with a walk or a
	// relink or held by a stalled response; a full queue stalls the request side.
	pdl_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.full     (q_full),
		.pop      (q_pop),
		.head     (q_head)
	);

	// List engine: shift the slot chain and drive the response register,
	// which lets the engine run ahead of a stalled consumer by one result.
	pdl_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (q_head),
		.pop       (q_pop),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall)
	);

endmodule

@@ src/pdl_checker.sv @@
// ----------------------------------------------------------------------------
// pdl_checker
// Port-level checks of the draw list, bound to the top level.
// ----------------------------------------------------------------------------
module pdl_checker import pdl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input req_t req,
	input logic req_stall,
	input logic rsp_valid,
	input rsp_t rsp,
	input logic rsp_stall,
	input logic cfg_valid,
	input logic cfg_data,
	input logic cfg_ready
);

	// A stalled response holds.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// Only a walk in progress gives a non-final result, always with ok status.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.last)
		else $error("status result not marked last");

	// Empty or disabled status carries no entry and no priority.
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp.status == ST_EMPTY || rsp.status == ST_DISABLED)
		|-> rsp.entry_out == '0 && rsp.priority_out == '0)
		else $error("walk status carries payload");

	// Misuse reports priority zero.
	a_misuse_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_MISUSE |-> rsp.priority_out == '0)
		else $error("misuse result carries priority");

	// Within one walk, consecutive entries come out in priority order.
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_stall && !rsp.last && rsp.status == ST_OK
		##1 rsp_valid && !rsp_stall
		|-> rsp.priority_out >= $past(rsp.priority_out))
		else $error("walk out of priority order");

endmodule

bind priority_ordered_draw_list pdl_checker u_pdl_checker (.*);

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the priority-ordered draw list. Requests go in on a
// valid/stall channel and results come back on another. A software copy of
// the sorted list predicts every result, including misuse replies, empty and
// disabled walk status, and the order of entries that share a priority. A
// short directed sequence is followed by a few hundred random requests with
// random idle cycles on both sides, one long receiver hold-off, and draw
// enable writes between phases.
// ----------------------------------------------------------------------------
module tb_top import pdl_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int QuietLimit = 1000;   // cycles without any handshake
	localparam int HoldCycles = 120;    // long receiver hold-off
	localparam int MaxReports = 40;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	req_t req;
	logic req_stall;
	logic rsp_valid;
	rsp_t rsp;
	logic rsp_stall;
	logic cfg_valid;
	logic cfg_data;
	logic cfg_ready;

	// One step of the directed sequence: a request, or a draw enable write.
	typedef struct packed {
		logic  is_cfg;
		logic  cfg_val;
		req_t  rq;
		logic  typed;
		rsp_t  fixed;
	} stim_row_t;

	// Software copy of the list.
	logic [EntryW-1:0] slot_ent [NumIds];
	logic [PrioW-1:0]  slot_pri [NumIds];
	logic              ent_listed [NumIds];
	logic [PrioW-1:0]  ent_pri [NumIds];
	int                list_len;
	logic              draw_en_model;

	// Results still owed by the block, oldest first.
	rsp_t      rsp_due[$];
	stim_row_t stim_rows[$];

	int errors;
	int n_requests;
	int n_walks;
	int n_misuse;
	int n_results;
	int n_cfg_writes;
	int longest_walk;
	int hold_left;     // set by the stimulus, counted down by the receiver
	logic calm;        // suppress idling on both sides

	priority_ordered_draw_list i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.rsp_stall (rsp_stall),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic req_t mk_req(input op_t o, input logic [EntryW-1:0] e,
			input logic [PrioW-1:0] p);
		req_t r;
		r.op = o;
		r.entry = e;
		r.priority_req = p;
		return r;
	endfunction

	function automatic rsp_t mk_rsp(input logic [EntryW-1:0] e,
			input logic [PrioW-1:0] p, input logic lst, input status_t st);
		rsp_t r;
		r.entry_out = e;
		r.priority_out = p;
		r.last = lst;
		r.status = st;
		return r;
	endfunction

	// Unlink an entry and close the gap behind it.
	function automatic void drop_from_list(input logic [EntryW-1:0] e);
		int pos;
		pos = list_len;
		for (int i = list_len - 1; i >= 0; i--)
			if (slot_ent[i] == e)
				pos = i;
		if (pos >= list_len)
			return;
		for (int i = pos; i + 1 < list_len; i++) begin
			slot_ent[i] = slot_ent[i + 1];
			slot_pri[i] = slot_pri[i + 1];
		end
		list_len--;
		ent_listed[e] = 1'b0;
	endfunction

	// Link an entry after every entry of lower or equal priority.
	function automatic void place_in_list(input logic [EntryW-1:0] e,
			input logic [PrioW-1:0] p);
		int pos;
		pos = 0;
		if (list_len >= NumIds)
			return;
		while (pos < list_len && slot_pri[pos] <= p)
			pos++;
		for (int i = list_len; i > pos; i--) begin
			slot_ent[i] = slot_ent[i - 1];
			slot_pri[i] = slot_pri[i - 1];
		end
		slot_ent[pos] = e;
		slot_pri[pos] = p;
		list_len++;
		ent_listed[e] = 1'b1;
		ent_pri[e] = p;
	endfunction

	// Update the list copy for one accepted request and queue its results.
	function automatic void apply_request(input req_t r);
		logic idx_ok;
		logic listed;
		logic [PrioW-1:0] old_pri;
		idx_ok = int'(r.entry) < NumEntries;
		listed = idx_ok && ent_listed[r.entry];
		case (r.op)
			OP_INSERT: begin
				if (!idx_ok || listed) begin
					rsp_due.push_back(mk_rsp(r.entry, '0, 1'b1, ST_MISUSE));
					n_misuse++;
				end else begin
					place_in_list(r.entry, r.priority_req);
					rsp_due.push_back(mk_rsp(r.entry, r.priority_req, 1'b1, ST_OK));
				end
			end
			OP_REMOVE: begin
				if (!listed) begin
					rsp_due.push_back(mk_rsp(r.entry, '0, 1'b1, ST_MISUSE));
					n_misuse++;
				end else begin
					old_pri = ent_pri[r.entry];
					drop_from_list(r.entry);
					rsp_due.push_back(mk_rsp(r.entry, old_pri, 1'b1, ST_OK));
				end
			end
			OP_CHANGE: begin
				if (!listed) begin
					rsp_due.push_back(mk_rsp(r.entry, '0, 1'b1, ST_MISUSE));
					n_misuse++;
				end else begin
					drop_from_list(r.entry);
					place_in_list(r.entry, r.priority_req);
					rsp_due.push_back(mk_rsp(r.entry, r.priority_req, 1'b1, ST_OK));
				end
			end
			default: begin
				n_walks++;
				// disabled status wins over empty status
				if (!draw_en_model)
					rsp_due.push_back(mk_rsp('0, '0, 1'b1, ST_DISABLED));
				else if (list_len == 0)
					rsp_due.push_back(mk_rsp('0, '0, 1'b1, ST_EMPTY));
				else begin
					for (int i = 0; i < list_len; i++)
						rsp_due.push_back(mk_rsp(slot_ent[i], slot_pri[i],
							i + 1 == list_len, ST_OK));
					if (list_len > longest_walk)
						longest_walk = list_len;
				end
			end
		endcase
	endfunction

	// Pick a listed (or unlisted) entry at random; any entry if none qualify.
	function automatic logic [EntryW-1:0] pick_entry(input logic listed);
		int n;
		int k;
		logic [EntryW-1:0] e;
		n = 0;
		for (int i = 0; i < NumIds; i++)
			if (ent_listed[i] == listed)
				n++;
		if (n == 0)
			return EntryW'($urandom_range(NumIds - 1));
		k = $urandom_range(n - 1);
		e = '0;
		for (int i = 0; i < NumIds; i++)
			if (ent_listed[i] == listed) begin
				if (k == 0)
					e = EntryW'(i);
				k--;
			end
		return e;
	endfunction

	// Favor the extremes and a few shared values so ties are common.
	function automatic logic [PrioW-1:0] pick_prio();
		case ($urandom_range(3))
			0: return $urandom_range(1) ? 8'd255 : 8'd0;
			1: return PrioW'($urandom_range(3) * 64);
			default: return PrioW'($urandom_range(255));
		endcase
	endfunction

	// Offer one request, idle at random first, and hold it until accepted.
	// Leave valid high afterwards; the next request or the caller drops it.
	task automatic send_req(input req_t r, input logic typed, input rsp_t fixed);
		while (!calm && $urandom_range(99) < 31) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (req_stall !== 1'b0)
			@(posedge clk);
		n_requests++;
		apply_request(r);
		// where the result is spelled out in the directed rows, check that instead
		if (typed) begin
			void'(rsp_due.pop_back());
			rsp_due.push_back(fixed);
		end
	endtask

	// Drop the request valid, drain all owed results, then write draw enable.
	task automatic write_draw_enable(input logic v);
		req_valid <= 1'b0;
		while (rsp_due.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		cfg_valid <= 1'b0;
		draw_en_model = v;
		n_cfg_writes++;
	endtask

	// Mostly well-formed requests against the current list, some noise.
	task automatic run_random(input int count, input int hold_at,
			input int calm_from, input int calm_to);
		int n;
		req_t r;
		for (int i = 0; i < count; i++) begin
			if (i == hold_at)
				hold_left = HoldCycles;
			calm = (i >= calm_from && i < calm_to);
			n = $urandom_range(99);
			if (n < 10)
				r = mk_req(op_t'($urandom_range(3)), EntryW'($urandom_range(NumIds - 1)),
					PrioW'($urandom_range(255)));
			else if (n < 22)
				r = mk_req(OP_WALK, EntryW'($urandom_range(NumIds - 1)), pick_prio());
			else if (n < (list_len < 24 ? 62 : 40))
				r = mk_req(OP_INSERT, pick_entry(1'b0), pick_prio());
			else if (n < 82)
				r = mk_req(OP_CHANGE, pick_entry(1'b1), pick_prio());
			else
				r = mk_req(OP_REMOVE, pick_entry(1'b1), pick_prio());
			send_req(r, 1'b0, '0);
		end
		calm = 1'b0;
	endtask

	function automatic stim_row_t req_row(input op_t o, input logic [EntryW-1:0] e,
			input logic [PrioW-1:0] p);
		stim_row_t s;
		s = '0;
		s.rq = mk_req(o, e, p);
		return s;
	endfunction

	function automatic stim_row_t chk_row(input op_t o, input logic [EntryW-1:0] e,
			input logic [PrioW-1:0] p, input rsp_t want);
		stim_row_t s;
		s = req_row(o, e, p);
		s.typed = 1'b1;
		s.fixed = want;
		return s;
	endfunction

	function automatic stim_row_t cfg_row(input logic v);
		stim_row_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.cfg_val = v;
		return s;
	endfunction

	// Receiver: check each accepted result, then pick the next stall value.
	initial begin : receiver
		rsp_t want;
		rsp_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
				n_results++;
				if (rsp_due.size() == 0) begin
					errors++;
					if (errors <= MaxReports)
						$display("%t: unexpected result: entry %0d prio %0d last %0d status %0d",
							$time, rsp.entry_out, rsp.priority_out, rsp.last, rsp.status);
				end else begin
					want = rsp_due.pop_front();
					if (rsp.entry_out !== want.entry_out
							|| rsp.priority_out !== want.priority_out
							|| rsp.last !== want.last
							|| rsp.status !== want.status) begin
						errors++;
						if (errors <= MaxReports)
							$display("%t: mismatch: expected entry %0d prio %0d last %0d status %0d, got entry %0d prio %0d last %0d status %0d",
								$time, want.entry_out, want.priority_out, want.last,
								want.status, rsp.entry_out, rsp.priority_out, rsp.last,
								rsp.status);
					end
				end
			end
			// hold off for a long stretch so the block backs up into its input
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (calm)
				rsp_stall <= 1'b0;
			else
				rsp_stall <= ($urandom_range(99) < 31);
		end
	end

	// Watchdog: end the run when no channel moves for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		wait (arst_n === 1'b1);
		while (quiet < QuietLimit) begin
			@(posedge clk);
			if ((req_valid === 1'b1 && req_stall === 1'b0)
					|| (rsp_valid === 1'b1 && rsp_stall === 1'b0)
					|| (cfg_valid === 1'b1 && cfg_ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%t: no handshake for %0d cycles, %0d results still owed",
			$time, quiet, rsp_due.size());
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin : stimulus
		stim_row_t row;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_data = 1'b0;
		calm = 1'b0;
		hold_left = 0;
		errors = 0;
		n_requests = 0;
		n_walks = 0;
		n_misuse = 0;
		n_results = 0;
		n_cfg_writes = 0;
		longest_walk = 0;
		list_len = 0;
		draw_en_model = 1'b1;
		for (int i = 0; i < NumIds; i++) begin
			slot_ent[i] = '0;
			slot_pri[i] = '0;
			ent_listed[i] = 1'b0;
			ent_pri[i] = '0;
		end

		// Directed: empty and disabled walks, misuse, extremes, ties,
		// a change to the same priority, and list edits while disabled.
		stim_rows.push_back(chk_row(OP_WALK, 5'd0, 8'd0, mk_rsp('0, '0, 1'b1, ST_EMPTY)));
		stim_rows.push_back(cfg_row(1'b0));
		stim_rows.push_back(chk_row(OP_WALK, 5'd31, 8'd255,
			mk_rsp('0, '0, 1'b1, ST_DISABLED)));
		stim_rows.push_back(cfg_row(1'b1));
		stim_rows.push_back(chk_row(OP_REMOVE, 5'd0, 8'd0, mk_rsp(5'd0, '0, 1'b1, ST_MISUSE)));
		stim_rows.push_back(chk_row(OP_CHANGE, 5'd31, 8'd9,
			mk_rsp(5'd31, '0, 1'b1, ST_MISUSE)));
		stim_rows.push_back(chk_row(OP_INSERT, 5'd0, 8'd0, mk_rsp(5'd0, 8'd0, 1'b1, ST_OK)));
		stim_rows.push_back(chk_row(OP_INSERT, 5'd31, 8'd255,
			mk_rsp(5'd31, 8'd255, 1'b1, ST_OK)));
		stim_rows.push_back(chk_row(OP_INSERT, 5'd0, 8'd7, mk_rsp(5'd0, '0, 1'b1, ST_MISUSE)));
		stim_rows.push_back(req_row(OP_INSERT, 5'd5, 8'd100));
		stim_rows.push_back(req_row(OP_INSERT, 5'd6, 8'd100));
		stim_rows.push_back(req_row(OP_INSERT, 5'd7, 8'd0));
		stim_rows.push_back(req_row(OP_WALK, 5'd0, 8'd0));
		stim_rows.push_back(req_row(OP_CHANGE, 5'd5, 8'd100));
		stim_rows.push_back(req_row(OP_WALK, 5'd0, 8'd0));
		stim_rows.push_back(chk_row(OP_CHANGE, 5'd31, 8'd0, mk_rsp(5'd31, 8'd0, 1'b1, ST_OK)));
		stim_rows.push_back(chk_row(OP_REMOVE, 5'd6, 8'd0, mk_rsp(5'd6, 8'd100, 1'b1, ST_OK)));
		stim_rows.push_back(chk_row(OP_REMOVE, 5'd6, 8'd0, mk_rsp(5'd6, '0, 1'b1, ST_MISUSE)));
		stim_rows.push_back(req_row(OP_WALK, 5'd0, 8'd0));
		stim_rows.push_back(cfg_row(1'b0));
		stim_rows.push_back(chk_row(OP_INSERT, 5'd20, 8'd50, mk_rsp(5'd20, 8'd50, 1'b1, ST_OK)));
		stim_rows.push_back(chk_row(OP_WALK, 5'd0, 8'd0, mk_rsp('0, '0, 1'b1, ST_DISABLED)));
		stim_rows.push_back(cfg_row(1'b1));
		stim_rows.push_back(req_row(OP_WALK, 5'd0, 8'd0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			row = stim_rows[i];
			if (row.is_cfg)
				write_draw_enable(row.cfg_val);
			else
				send_req(row.rq, row.typed, row.fixed);
		end

		// Random phases: a long hold-off and a calm stretch in the first,
		// drawing disabled in the second, a full list before the third.
		run_random(100, 20, 60, 95);
		write_draw_enable(1'b0);
		run_random(30, -1, 0, 0);
		write_draw_enable(1'b1);
		while (list_len < NumIds)
			send_req(mk_req(OP_INSERT, pick_entry(1'b0), pick_prio()), 1'b0, '0);
		send_req(mk_req(OP_WALK, 5'd0, 8'd0), 1'b0, '0);
		run_random(90, -1, 0, 0);
		req_valid <= 1'b0;

		// Drain, then give stray results a chance to show up.
		while (rsp_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("tb_top: %0d requests (%0d walks, %0d misuse), %0d results checked",
			n_requests, n_walks, n_misuse, n_results);
		$display("tb_top: longest walk %0d entries, %0d draw enable writes",
			longest_walk, n_cfg_writes);
		if (errors == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
